FILE: hw/rtl/vector_gcd_reduction_core_defines.svh
// ----------------------------------------------------------------------------
// vector gcd reduction core assertion macros
// shared concurrent assertion forms used by the port checker
// ----------------------------------------------------------------------------
`ifndef VECTOR_GCD_REDUCTION_CORE_DEFINES_SVH
`define VECTOR_GCD_REDUCTION_CORE_DEFINES_SVH

// property held at every clock edge outside reset
`define VGR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication whose consequent is checked in the following cycle
`define VGR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  `VGR_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

FILE: hw/rtl/vgr_pkg.sv
// ----------------------------------------------------------------------------
// vgr_pkg
// shared types, constants and helpers of the vector gcd reduction core
// ----------------------------------------------------------------------------
package vgr_pkg;

  localparam int unsigned COMP_W = 16;
  localparam int unsigned MAG_W  = COMP_W;
  localparam int unsigned EXT_W  = COMP_W + 1;
  localparam int unsigned CNT_W  = $clog2(MAG_W);

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic signed [EXT_W-1:0]  ext_t;
  typedef logic        [MAG_W-1:0]  mag_t;

  typedef enum logic [1:0] {
    COMP_X = 2'd0,
    COMP_Y = 2'd1,
    COMP_Z = 2'd2
  } comp_sel_e;

  typedef enum logic {
    PAIR_XY = 1'b0,
    PAIR_GZ = 1'b1
  } pair_sel_e;

  typedef enum logic {
    DIV_EUCLID = 1'b0,
    DIV_QUOT   = 1'b1
  } div_sel_e;

  typedef struct packed {
    logic      capture;
    logic      load_pair;
    pair_sel_e pair_sel;
    logic      set_g_max;
    logic      div_start;
    div_sel_e  div_sel;
    comp_sel_e comp_sel;
    logic      euclid_step;
    logic      set_g_b;
    logic      store_quot;
    logic      write_out;
  } dp_cmd_t;

  typedef struct packed {
    logic zero_in;
    logic pair_zero;
    logic div_done;
    logic rem_zero;
    logic out_space;
  } dp_status_t;

  function automatic ext_t sext(comp_t v);
    return {v[COMP_W-1], v};
  endfunction

  // magnitude of a widened value, at most 2^(COMP_W-1)
  function automatic mag_t abs_mag(ext_t v);
    ext_t neg;
    neg = -v;
    return v[EXT_W-1] ? neg[MAG_W-1:0] : v[MAG_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/vgr_div.sv
// ----------------------------------------------------------------------------
// vgr_div
// radix-2 restoring divider with truncating signed quotient and remainder
// ----------------------------------------------------------------------------
module vgr_div
  import vgr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  ext_t dividend_i,
  input  ext_t divisor_i,
  output logic done_o,
  output ext_t quot_o,
  output ext_t rem_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  mag_t             q_q, q_d;
  mag_t             r_q, r_d;
  mag_t             dvs_q, dvs_d;
  logic             qneg_q, qneg_d;
  logic             rneg_q, rneg_d;
  logic [MAG_W:0]   r_shift;
  logic [MAG_W:0]   r_diff;
  ext_t             q_ext;
  ext_t             r_ext;

  always_comb begin
    r_shift = {r_q, q_q[MAG_W-1]};
    r_diff  = r_shift - {1'b0, dvs_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    q_d     = q_q;
    r_d     = r_q;
    dvs_d   = dvs_q;
    qneg_d  = qneg_q;
    rneg_d  = rneg_q;
    if (start_i) begin
      q_d    = abs_mag(dividend_i);
      r_d    = '0;
      dvs_d  = abs_mag(divisor_i);
      cnt_d  = CNT_W'(MAG_W - 1);
      busy_d = 1'b1;
      qneg_d = dividend_i[EXT_W-1] ^ divisor_i[EXT_W-1];
      rneg_d = dividend_i[EXT_W-1];
    end else if (busy_q) begin
      if (!r_diff[MAG_W]) begin
        r_d = r_diff[MAG_W-1:0];
        q_d = {q_q[MAG_W-2:0], 1'b1};
      end else begin
        r_d = r_shift[MAG_W-1:0];
        q_d = {q_q[MAG_W-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q    <= q_d;
    r_q    <= r_d;
    dvs_q  <= dvs_d;
    qneg_q <= qneg_d;
    rneg_q <= rneg_d;
  end

  // remainder takes the dividend sign, quotient the xor of both signs
  assign q_ext  = {1'b0, q_q};
  assign r_ext  = {1'b0, r_q};
  assign quot_o = qneg_q ? -q_ext : q_ext;
  assign rem_o  = rneg_q ? -r_ext : r_ext;
  assign done_o = done_q;

endmodule

FILE: hw/rtl/vgr_dp.sv
// ----------------------------------------------------------------------------
// vgr_dp
// operand, gcd and result registers around the shared divider
// ----------------------------------------------------------------------------
module vgr_dp
  import vgr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o,
  input  comp_t      comp_x_i,
  input  comp_t      comp_y_i,
  input  comp_t      comp_z_i,
  output comp_t      red_x_o,
  output comp_t      red_y_o,
  output comp_t      red_z_o,
  output comp_t      divisor_o,
  output logic       zero_vector_o,
  output logic       out_valid_o,
  input  logic       out_ready_i
);

  comp_t x_q, y_q, z_q;
  ext_t  a_q, b_q, g_q;
  comp_t qx_q, qy_q, qz_q;
  comp_t red_x_q, red_y_q, red_z_q, divisor_q;
  logic  zero_q;
  logic  out_valid_q, out_valid_d;
  mag_t  a_mag, b_mag;
  ext_t  div_a, div_b, div_quot, div_rem;
  ext_t  comp_sel_val;
  logic  div_done;
  logic  zero_in;

  assign zero_in = (x_q == '0) && (y_q == '0) && (z_q == '0);
  assign a_mag   = abs_mag(a_q);
  assign b_mag   = abs_mag(b_q);

  always_comb begin
    case (cmd_i.comp_sel)
      COMP_X:  comp_sel_val = sext(x_q);
      COMP_Y:  comp_sel_val = sext(y_q);
      COMP_Z:  comp_sel_val = sext(z_q);
      default: comp_sel_val = sext(z_q);
    endcase
  end

  always_comb begin
    case (cmd_i.div_sel)
      DIV_EUCLID: begin
        div_a = a_q;
        div_b = b_q;
      end
      DIV_QUOT: begin
        div_a = comp_sel_val;
        div_b = g_q;
      end
      default: begin
        div_a = a_q;
        div_b = b_q;
      end
    endcase
  end

  vgr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      x_q <= comp_x_i;
      y_q <= comp_y_i;
      z_q <= comp_z_i;
    end
    if (cmd_i.load_pair) begin
      case (cmd_i.pair_sel)
        PAIR_XY: begin
          a_q <= sext(x_q);
          b_q <= sext(y_q);
        end
        PAIR_GZ: begin
          a_q <= g_q;
          b_q <= sext(z_q);
        end
        default: begin
          a_q <= sext(x_q);
          b_q <= sext(y_q);
        end
      endcase
    end else if (cmd_i.euclid_step) begin
      a_q <= b_q;
      b_q <= div_rem;
    end
    // zero operand: gcd is the larger magnitude, never negative
    if (cmd_i.set_g_max) begin
      g_q <= (a_mag >= b_mag) ? {1'b0, a_mag} : {1'b0, b_mag};
    end else if (cmd_i.set_g_b) begin
      g_q <= b_q;
    end
    if (cmd_i.store_quot) begin
      case (cmd_i.comp_sel)
        COMP_X:  qx_q <= div_quot[COMP_W-1:0];
        COMP_Y:  qy_q <= div_quot[COMP_W-1:0];
        COMP_Z:  qz_q <= div_quot[COMP_W-1:0];
        default: qz_q <= div_quot[COMP_W-1:0];
      endcase
    end
    if (cmd_i.write_out) begin
      if (zero_in) begin
        red_x_q   <= '0;
        red_y_q   <= '0;
        red_z_q   <= '0;
        divisor_q <= '0;
        zero_q    <= 1'b1;
      end else begin
        red_x_q   <= qx_q;
        red_y_q   <= qy_q;
        red_z_q   <= qz_q;
        divisor_q <= g_q[COMP_W-1:0];
        zero_q    <= 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q & ~out_ready_i;
    if (cmd_i.write_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign status_o.zero_in   = zero_in;
  assign status_o.pair_zero = (a_q == '0) || (b_q == '0);
  assign status_o.div_done  = div_done;
  assign status_o.rem_zero  = (div_rem == '0);
  assign status_o.out_space = ~out_valid_q | out_ready_i;

  assign red_x_o       = red_x_q;
  assign red_y_o       = red_y_q;
  assign red_z_o       = red_z_q;
  assign divisor_o     = divisor_q;
  assign zero_vector_o = zero_q;
  assign out_valid_o   = out_valid_q;

endmodule

FILE: hw/rtl/vgr_ctrl.sv
// ----------------------------------------------------------------------------
// vgr_ctrl
// sequencer for the two euclid passes and the three final divisions
// ----------------------------------------------------------------------------
module vgr_ctrl
  import vgr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output dp_cmd_t    cmd_o,
  input  dp_status_t status_i
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CHECK  = 7'b0000010,
    S_PAIR   = 7'b0000100,
    S_MOD    = 7'b0001000,
    S_NEXT   = 7'b0010000,
    S_QSTART = 7'b0100000,
    S_QWAIT  = 7'b1000000
  } state_e;

  // result write is folded into the last division and the zero check
  state_e    state_q, state_d;
  pair_sel_e phase_q, phase_d;
  comp_sel_e idx_q, idx_d;
  logic      wr_pend_q, wr_pend_d;

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    idx_d      = idx_q;
    wr_pend_d  = wr_pend_q;
    cmd_o      = '0;
    cmd_o.comp_sel = idx_q;
    in_ready_o = 1'b0;

    // a finished result waits here until the output register frees up
    if (wr_pend_q && status_i.out_space) begin
      cmd_o.write_out = 1'b1;
      wr_pend_d       = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        in_ready_o = ~wr_pend_q;
        if (in_valid_i && !wr_pend_q) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status_i.zero_in) begin
          wr_pend_d = 1'b1;
          state_d   = S_IDLE;
        end else begin
          cmd_o.load_pair = 1'b1;
          cmd_o.pair_sel  = PAIR_XY;
          phase_d         = PAIR_XY;
          state_d         = S_PAIR;
        end
      end
      S_PAIR: begin
        if (status_i.pair_zero) begin
          cmd_o.set_g_max = 1'b1;
          state_d         = S_NEXT;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_EUCLID;
          state_d         = S_MOD;
        end
      end
      S_MOD: begin
        if (status_i.div_done) begin
          if (status_i.rem_zero) begin
            cmd_o.set_g_b = 1'b1;
            state_d       = S_NEXT;
          end else begin
            cmd_o.euclid_step = 1'b1;
            state_d           = S_PAIR;
          end
        end
      end
      S_NEXT: begin
        if (phase_q == PAIR_XY) begin
          cmd_o.load_pair = 1'b1;
          cmd_o.pair_sel  = PAIR_GZ;
          phase_d         = PAIR_GZ;
          state_d         = S_PAIR;
        end else begin
          idx_d   = COMP_X;
          state_d = S_QSTART;
        end
      end
      S_QSTART: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_QUOT;
        state_d         = S_QWAIT;
      end
      S_QWAIT: begin
        cmd_o.div_sel = DIV_QUOT;
        if (status_i.div_done) begin
          cmd_o.store_quot = 1'b1;
          case (idx_q)
            COMP_X: begin
              idx_d   = COMP_Y;
              state_d = S_QSTART;
            end
            COMP_Y: begin
              idx_d   = COMP_Z;
              state_d = S_QSTART;
            end
            default: begin
              wr_pend_d = 1'b1;
              state_d   = S_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      phase_q   <= PAIR_XY;
      idx_q     <= COMP_X;
      wr_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      idx_q     <= idx_d;
      wr_pend_q <= wr_pend_d;
    end
  end

endmodule

FILE: hw/rtl/vector_gcd_reduction_core.sv
// ----------------------------------------------------------------------------
// vector_gcd_reduction_core
// reduces a three-component signed vector by its truncating-euclid gcd
// ----------------------------------------------------------------------------
// One transaction in carries x, y, z; one transaction out carries each
// component divided by g = gcd(gcd(x, y), z), g itself (its sign is what
// euclid with a truncating remainder leaves, so it can be negative) and a
// flag for the all-zero vector, which comes out unchanged with g = 0. Items
// are handled one at a time. All remainders and quotients go through a single
// radix-2 divider that takes one operation at a time, so the time an item
// occupies the block, from its acceptance until the next transaction can be
// taken, grows with the total number of euclid remainder steps of both gcd
// passes and is longest for fibonacci-like inputs; a zero vector skips the
// divider altogether. A new transaction is taken while the previous result
// still waits in the output register.
module vector_gcd_reduction_core
  import vgr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  comp_t comp_x_i,
  input  comp_t comp_y_i,
  input  comp_t comp_z_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output comp_t red_x_o,
  output comp_t red_y_o,
  output comp_t red_z_o,
  output comp_t divisor_o,
  output logic  zero_vector_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  vgr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  vgr_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .comp_x_i      (comp_x_i),
    .comp_y_i      (comp_y_i),
    .comp_z_i      (comp_z_i),
    .red_x_o       (red_x_o),
    .red_y_o       (red_y_o),
    .red_z_o       (red_z_o),
    .divisor_o     (divisor_o),
    .zero_vector_o (zero_vector_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i)
  );

endmodule

FILE: hw/rtl/vgr_checker.sv
// ----------------------------------------------------------------------------
// vgr_checker
// port-level checks on the vector gcd reduction core, bound to the top level
// ----------------------------------------------------------------------------
`include "vector_gcd_reduction_core_defines.svh"

module vgr_checker
  import vgr_pkg::*;
(
  input logic  clk_i,
  input logic  rst_ni,
  input logic  in_valid_i,
  input logic  in_ready_o,
  input comp_t comp_x_i,
  input comp_t comp_y_i,
  input comp_t comp_z_i,
  input logic  out_valid_o,
  input logic  out_ready_i,
  input comp_t red_x_o,
  input comp_t red_y_o,
  input comp_t red_z_o,
  input comp_t divisor_o,
  input logic  zero_vector_o
);

  // a stalled result keeps its payload
  `VGR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(red_x_o) && $stable(red_y_o) && $stable(red_z_o) && $stable(divisor_o) && $stable(zero_vector_o), "output changed while stalled")

  // zero vector comes out as all zeros with zero divisor
  `VGR_ASSERT(a_zero_out, clk_i, rst_ni, (out_valid_o && zero_vector_o) |-> (red_x_o == '0 && red_y_o == '0 && red_z_o == '0 && divisor_o == '0), "zero vector result not all zero")

  // any other vector has a non-zero divisor
  `VGR_ASSERT(a_div_nonzero, clk_i, rst_ni, (out_valid_o && !zero_vector_o) |-> (divisor_o != '0), "zero divisor on non-zero vector")

  // one item at a time: no second transaction straight after an accepted one
  `VGR_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "input taken while busy")

endmodule

bind vector_gcd_reduction_core vgr_checker u_vgr_checker (.*);

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// vector gcd reduction core: directed and random vectors against a predictor
// ----------------------------------------------------------------------------
// A table of hand-picked vectors goes first: the zero vector, lone non-zero
// components, the range extremes and the most negative code, each with the
// expected reduction typed in where it is plain. The remaining rows and a
// random mix run through a truncating-euclid predictor. The mix holds full
// range values, vectors with a large common factor, partly zero vectors,
// fibonacci chains for the longest euclid runs, small values and extremes.
// Both handshakes idle at random, with stretches of back-to-back traffic.
module tb
  import vgr_pkg::*;
;

  localparam int N_DIRECTED = 24;
  localparam int N_RANDOM   = 1126;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_WAIT = 400;

  typedef struct packed {
    comp_t rx;
    comp_t ry;
    comp_t rz;
    comp_t g;
    logic  zv;
  } reduced_vec_t;

  typedef struct packed {
    comp_t        x;
    comp_t        y;
    comp_t        z;
    logic         typed;
    reduced_vec_t want;
  } vec_case_t;

  logic  clk_i;
  logic  rst_ni;
  logic  in_valid_i;
  logic  in_ready_o;
  comp_t comp_x_i;
  comp_t comp_y_i;
  comp_t comp_z_i;
  logic  out_valid_o;
  logic  out_ready_i;
  comp_t red_x_o;
  comp_t red_y_o;
  comp_t red_z_o;
  comp_t divisor_o;
  logic  zero_vector_o;

  reduced_vec_t pending_reductions[$];
  vec_case_t    dir_cases [N_DIRECTED];
  int           fib [24];
  int           extreme_vals [8];
  int           mismatches;
  int           idle_cycles;
  bit           in_burst;
  bit           out_burst;

  vector_gcd_reduction_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .comp_x_i      (comp_x_i),
    .comp_y_i      (comp_y_i),
    .comp_z_i      (comp_z_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .red_x_o       (red_x_o),
    .red_y_o       (red_y_o),
    .red_z_o       (red_z_o),
    .divisor_o     (divisor_o),
    .zero_vector_o (zero_vector_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // remainder takes the sign of the dividend, so the gcd may end negative
  function automatic longint trunc_euclid_gcd(longint a, longint b);
    longint r;
    longint aa;
    longint ab;
    if (a == 0 || b == 0) begin
      aa = (a < 0) ? -a : a;
      ab = (b < 0) ? -b : b;
      return (aa > ab) ? aa : ab;
    end
    r = a % b;
    while (r != 0) begin
      a = b;
      b = r;
      r = a % b;
    end
    return b;
  endfunction

  // exact at wide width; a quotient or divisor of +2^15 wraps on the cast
  function automatic reduced_vec_t predict_reduction(comp_t x, comp_t y, comp_t z);
    reduced_vec_t res;
    longint       lx;
    longint       ly;
    longint       lz;
    longint       g;
    lx = x;
    ly = y;
    lz = z;
    if (lx == 0 && ly == 0 && lz == 0) begin
      res = '{rx: '0, ry: '0, rz: '0, g: '0, zv: 1'b1};
      return res;
    end
    g = trunc_euclid_gcd(trunc_euclid_gcd(lx, ly), lz);
    res.rx = comp_t'(lx / g);
    res.ry = comp_t'(ly / g);
    res.rz = comp_t'(lz / g);
    res.g  = comp_t'(g);
    res.zv = 1'b0;
    return res;
  endfunction

  function automatic int with_rand_sign(int mag);
    return ($urandom_range(0, 1) != 0) ? -mag : mag;
  endfunction

  function automatic comp_t scaled_comp(int g);
    return comp_t'(with_rand_sign(g * $urandom_range(0, 32767 / g)));
  endfunction

  task automatic send_vector(input comp_t x, input comp_t y, input comp_t z,
                             input reduced_vec_t want);
    int unsigned gap;
    gap = in_burst ? 0 : $urandom_range(0, 16);
    if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    comp_x_i   = x;
    comp_y_i   = y;
    comp_z_i   = z;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_reductions = {pending_reductions, want};
  endtask

  task automatic send_random_vector();
    int          pick;
    int          g;
    int          i;
    comp_t       x;
    comp_t       y;
    comp_t       z;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      x = comp_t'($urandom);
      y = comp_t'($urandom);
      z = comp_t'($urandom);
    end else if (pick < 55) begin
      // large common factor, so the division does real work
      g = $urandom_range(1, 2000);
      x = scaled_comp(g);
      y = scaled_comp(g);
      z = scaled_comp(g);
    end else if (pick < 67) begin
      x = ($urandom_range(0, 1) != 0) ? comp_t'(0) : comp_t'($urandom);
      y = ($urandom_range(0, 1) != 0) ? comp_t'(0) : comp_t'($urandom);
      z = ($urandom_range(0, 1) != 0) ? comp_t'(0) : comp_t'($urandom);
    end else if (pick < 77) begin
      // consecutive fibonacci terms give the longest euclid runs
      i = $urandom_range(3, 23);
      x = comp_t'(with_rand_sign(fib[i]));
      y = comp_t'(with_rand_sign(fib[i-1]));
      z = ($urandom_range(0, 1) != 0) ? comp_t'(with_rand_sign(fib[i-2]))
                                     : comp_t'($urandom);
    end else if (pick < 90) begin
      x = comp_t'($urandom_range(0, 16) - 8);
      y = comp_t'($urandom_range(0, 16) - 8);
      z = comp_t'($urandom_range(0, 16) - 8);
    end else begin
      x = comp_t'(extreme_vals[$urandom_range(0, 7)]);
      y = comp_t'(extreme_vals[$urandom_range(0, 7)]);
      z = comp_t'(extreme_vals[$urandom_range(0, 7)]);
    end
    send_vector(x, y, z, predict_reduction(x, y, z));
  endtask

  // result side: per-transaction stall, held high through bursts
  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    out_burst   = 1'b0;
    wait (rst_ni);
    forever begin
      stall = out_burst ? 0 : $urandom_range(0, 16);
      if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
      if (stall > 0) begin
        @(negedge clk_i);
        out_ready_i = 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready_i = 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    reduced_vec_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reductions.size() == 0) begin
        $error("unexpected result transaction: red %0d %0d %0d divisor %0d",
               red_x_o, red_y_o, red_z_o, divisor_o);
        mismatches++;
      end else begin
        want = pending_reductions.pop_front();
        if (red_x_o !== want.rx) begin
          $error("red_x: expected %0d, got %0d", want.rx, red_x_o);
          mismatches++;
        end
        if (red_y_o !== want.ry) begin
          $error("red_y: expected %0d, got %0d", want.ry, red_y_o);
          mismatches++;
        end
        if (red_z_o !== want.rz) begin
          $error("red_z: expected %0d, got %0d", want.rz, red_z_o);
          mismatches++;
        end
        if (divisor_o !== want.g) begin
          $error("divisor: expected %0d, got %0d", want.g, divisor_o);
          mismatches++;
        end
        if (zero_vector_o !== want.zv) begin
          $error("zero_vector: expected %0b, got %0b", want.zv, zero_vector_o);
          mismatches++;
        end
      end
    end
  end

  // watchdog: no transaction on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    comp_x_i    = '0;
    comp_y_i    = '0;
    comp_z_i    = '0;
    mismatches  = 0;
    idle_cycles = 0;
    in_burst    = 1'b0;

    fib[0] = 0;
    fib[1] = 1;
    for (int i = 2; i < 24; i++) fib[i] = fib[i-1] + fib[i-2];
    extreme_vals = '{0, 1, -1, 32767, -32767, -32768, 16384, -16384};

    // typed rows: zero vector, lone components, extremes, most negative code
    dir_cases = '{
      '{0, 0, 0, 1'b1, '{0, 0, 0, 0, 1'b1}},
      '{6, 0, 0, 1'b1, '{1, 0, 0, 6, 1'b0}},
      '{0, 0, -5, 1'b1, '{0, 0, -1, 5, 1'b0}},
      '{0, -9, 0, 1'b1, '{0, -1, 0, 9, 1'b0}},
      '{32767, 32767, 32767, 1'b1, '{1, 1, 1, 32767, 1'b0}},
      '{-32767, -32767, -32767, 1'b1, '{1, 1, 1, -32767, 1'b0}},
      '{-32768, 0, 0, 1'b1, '{-1, 0, 0, -32768, 1'b0}},
      '{-32768, -32768, -32768, 1'b1, '{1, 1, 1, -32768, 1'b0}},
      '{1, 1, 1, 1'b1, '{1, 1, 1, 1, 1'b0}},
      '{-1, -1, -1, 1'b1, '{1, 1, 1, -1, 1'b0}},
      '{12, 18, -30, 1'b0, '{0, 0, 0, 0, 1'b0}},
      '{-12, 18, 30, 1'b0, '{0, 0, 0, 0, 1'b0}},
      '{12, -18, 30, 1'b0, '{0, 0, 0, 0, 1'b0}},
      '{28657, 17711, 10946, 1'b0, '{0, 0, 0, 0, 1'b0}},
      '{-28657, 17711, -10946, 1'b0, '{0, 0, 0, 0, 1'b0}},
      '{32767, -32767, 1, 1'b0, '{0, 0, 0, 0, 1'b0}},
      '{-32768, 32767, 2, 1'b0, '{0, 0, 0, 0, 1'b0}},
      '{-32768, 16384, -8192, 1'b0, '{0, 0, 0, 0, 1'b0}},
      '{7, 0, 13, 1'b0, '{0, 0, 0, 0, 1'b0}},
      '{0, 35, -21, 1'b0, '{0, 0, 0, 0, 1'b0}},
      '{21845, -21846, 0, 1'b0, '{0, 0, 0, 0, 1'b0}},
      '{1024, -2048, 4096, 1'b0, '{0, 0, 0, 0, 1'b0}},
      '{-32767, 0, -32767, 1'b0, '{0, 0, 0, 0, 1'b0}},
      '{32767, -32768, -1, 1'b0, '{0, 0, 0, 0, 1'b0}}
    };

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_cases[i]) begin
      send_vector(dir_cases[i].x, dir_cases[i].y, dir_cases[i].z,
                  dir_cases[i].typed ? dir_cases[i].want
                                     : predict_reduction(dir_cases[i].x, dir_cases[i].y,
                                                         dir_cases[i].z));
    end

    repeat (N_RANDOM) send_random_vector();

    @(negedge clk_i);
    in_valid_i = 1'b0;

    while (pending_reductions.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
